/* rtl/fse_pkg.sv */
`timescale 1ns / 1ps
package fse_pkg;
  localparam int unsigned MaxHarmonics = 64;
  localparam int unsigned CoeffWidth   = 24;

  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpEval  = 2'd2;

  localparam logic CfgHarmonicCount = 1'b0;
  localparam logic CfgInversePeriod = 1'b1;

  localparam logic [31:0] SinC1 = 32'd1686629713;
  localparam logic [31:0] SinC3 = 32'd693598668;
  localparam logic [31:0] SinC5 = 32'd85569305;
  localparam logic [31:0] SinC7 = 32'd5026995;
  localparam logic [31:0] SinC9 = 32'd172272;
  localparam logic [31:0] Q30One = 32'd1073741824;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         index;
    logic signed [23:0] cos_coeff_in;
    logic signed [23:0] sin_coeff_in;
    logic signed [31:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] series_value;
    logic signed [23:0] cos_coeff_out;
    logic signed [23:0] sin_coeff_out;
    logic               index_error;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StRead, StXmul, StPrep, StMulGo, StMulWait, StFinish
  } state_e;

  // products of one term, in order
  typedef enum logic [2:0] {
    StepZ, StepR7, StepR5, StepR3, StepR1, StepSin, StepMac
  } step_e;
endpackage

/* rtl/fse_if.sv */
`timescale 1ns / 1ps
interface fse_in_if;
  logic              valid;
  logic              ready;
  fse_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fse_out_if;
  logic               valid;
  logic               ready;
  fse_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/fse_mul.sv */
`timescale 1ns / 1ps
// Serial signed multiplier, one multiplier bit per cycle.
module fse_mul #(
  parameter int unsigned Width = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [Width-1:0]   a_i,
  input  logic signed [Width-1:0]   b_i,
  output logic                      done_o,
  output logic signed [2*Width-1:0] p_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic signed [2*Width-1:0] acc_q, acc_d, ash_q, ash_d;
  logic [Width-1:0]         b_q, b_d;
  logic signed [2*Width-1:0] term;

  always_comb begin
    term = b_q[0] ? ash_q : '0;
    busy_d = busy_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    ash_d = ash_q;
    b_d = b_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      acc_d = '0;
      ash_d = {{Width{a_i[Width-1]}}, a_i};
      b_d = b_i;
    end else if (busy_q) begin
      acc_d = (cnt_q == CntW'(Width - 1)) ? acc_q - term : acc_q + term;
      ash_d = ash_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Width - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign p_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    b_q <= b_d;
  end
endmodule

/* rtl/fourier_series_evaluator.sv */
`timescale 1ns / 1ps
// Write: accepted in idle, no result. Read: the item goes through StRead to StFinish, which
// registers the result once the output slot is free. Evaluate: x/T and the seven products
// of each term share one bit-serial multiplier, two terms a harmonic. One item in work at a time;
// a waiting result does not block the input. Reset clears control and the entry valid bits and
// sets config to one harmonic and inverse period 2^24; unwritten entries read as zero.
module fourier_series_evaluator #(
  parameter int unsigned MAX_HARMONICS = fse_pkg::MaxHarmonics,
  parameter int unsigned COEFF_WIDTH   = fse_pkg::CoeffWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fse_in_if.sink      in_if,
  fse_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned AddrW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int unsigned MW    = 34;
  localparam int unsigned AccW  = 72;
  localparam logic signed [MW-1:0] QOne = MW'(fse_pkg::Q30One);

  logic signed [COEFF_WIDTH-1:0] cos_mem [MAX_HARMONICS];
  logic signed [COEFF_WIDTH-1:0] sin_mem [MAX_HARMONICS];
  logic [MAX_HARMONICS-1:0] vld_q;
  logic signed [COEFF_WIDTH-1:0] rd_c_q, rd_s_q;
  logic rd_v_q;
  logic [AddrW-1:0] raddr;

  logic [6:0]  hc_q;
  logic [31:0] ip_q;
  logic [6:0]  n_eff;

  fse_pkg::state_e st_q, st_d;
  fse_pkg::step_e step_q;
  fse_pkg::in_item_t it_q;
  fse_pkg::out_item_t res_q, res_d;
  logic out_v_q;

  logic in_acc, wr_en, res_free;
  logic [31:0] theta_q, ph_q, sph;
  logic [29:0] ulow;
  logic [6:0]  i_q;
  logic which_q, neg_q;
  logic signed [MW-1:0] u_q, z_q, r_q, prod_sh, sclamp;
  logic signed [AccW-1:0] acc_q, qv;
  logic signed [31:0] sat;
  logic signed [COEFF_WIDTH-1:0] coef;

  logic m_start, m_done;
  logic signed [MW-1:0] m_a, m_b;
  logic signed [2*MW-1:0] m_p;

  fse_mul #(.Width(MW)) u_mul (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .done_o(m_done), .p_o(m_p)
  );

  always_comb begin
    n_eff = hc_q;
    if (hc_q == 7'd0) n_eff = 7'd1;
    if (32'(hc_q) > 32'(MAX_HARMONICS)) n_eff = 7'(MAX_HARMONICS);
  end

  assign in_if.ready = (st_q == fse_pkg::StIdle);
  assign in_acc = in_if.valid && in_if.ready;
  assign wr_en = in_acc && (in_if.data.operation == fse_pkg::OpWrite)
                 && (32'(in_if.data.index) < 32'(MAX_HARMONICS));
  assign res_free = !out_v_q || out_if.ready;
  assign out_if.valid = out_v_q;
  assign out_if.data = res_q;

  assign raddr = (st_q == fse_pkg::StRead || st_q == fse_pkg::StFinish) ?
                 AddrW'(it_q.index) : AddrW'(i_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cos_mem[AddrW'(in_if.data.index)] <= COEFF_WIDTH'(in_if.data.cos_coeff_in);
      sin_mem[AddrW'(in_if.data.index)] <= COEFF_WIDTH'(in_if.data.sin_coeff_in);
    end
    rd_c_q <= cos_mem[raddr];
    rd_s_q <= sin_mem[raddr];
    rd_v_q <= vld_q[raddr];
  end

  always_comb begin
    coef = which_q ? rd_s_q : rd_c_q;
    if (!rd_v_q) coef = '0;
    sph = which_q ? ph_q : ph_q + 32'h4000_0000;
    ulow = sph[29:0];
    prod_sh = MW'(m_p >>> 30);
    sclamp = prod_sh;
    if (prod_sh > QOne) sclamp = QOne;
    if (prod_sh < 0) sclamp = '0;
    if (neg_q) sclamp = -sclamp;
    qv = acc_q >>> 30;
    if (qv > 72'sd2147483647) sat = 32'h7FFF_FFFF;
    else if (qv < -72'sd2147483648) sat = 32'h8000_0000;
    else sat = qv[31:0];
  end

  always_comb begin
    res_d = '0;
    if (it_q.operation == fse_pkg::OpEval) res_d.series_value = sat;
    else if ({1'b0, it_q.index} >= n_eff) res_d.index_error = 1'b1;
    else if (rd_v_q) begin
      res_d.cos_coeff_out = 24'(rd_c_q);
      if (it_q.index != 6'd0) res_d.sin_coeff_out = 24'(rd_s_q);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      fse_pkg::StIdle: if (in_acc) begin
        if (in_if.data.operation == fse_pkg::OpRead) st_d = fse_pkg::StRead;
        else if (in_if.data.operation == fse_pkg::OpEval) st_d = fse_pkg::StXmul;
      end
      fse_pkg::StRead: st_d = fse_pkg::StFinish;
      fse_pkg::StXmul: if (m_done) begin
        st_d = (n_eff == 7'd1) ? fse_pkg::StFinish : fse_pkg::StPrep;
      end
      fse_pkg::StPrep: st_d = fse_pkg::StMulGo;
      fse_pkg::StMulGo: st_d = fse_pkg::StMulWait;
      fse_pkg::StMulWait: if (m_done) begin
        if (step_q != fse_pkg::StepMac) st_d = fse_pkg::StMulGo;
        else if (!which_q) st_d = fse_pkg::StPrep;
        else if (i_q + 7'd1 >= n_eff) st_d = fse_pkg::StFinish;
        else st_d = fse_pkg::StPrep;
      end
      fse_pkg::StFinish: if (res_free) st_d = fse_pkg::StIdle;
      default: st_d = fse_pkg::StIdle;
    endcase
  end

  always_comb begin
    m_start = 1'b0;
    m_a = '0;
    m_b = '0;
    unique case (st_q)
      fse_pkg::StIdle: if (in_acc && in_if.data.operation == fse_pkg::OpEval) begin
        m_start = 1'b1;
        m_a = MW'(in_if.data.x_value);
        m_b = {2'b00, ip_q};
      end
      fse_pkg::StMulGo: begin
        m_start = 1'b1;
        unique case (step_q)
          fse_pkg::StepZ: begin m_a = u_q; m_b = u_q; end
          fse_pkg::StepR7: begin m_a = z_q; m_b = MW'(fse_pkg::SinC9); end
          fse_pkg::StepR5, fse_pkg::StepR3, fse_pkg::StepR1: begin
            m_a = z_q;
            m_b = r_q;
          end
          fse_pkg::StepSin: begin m_a = u_q; m_b = r_q; end
          fse_pkg::StepMac: begin m_a = MW'(coef); m_b = r_q; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= fse_pkg::StIdle;
      out_v_q <= 1'b0;
      vld_q <= '0;
      hc_q <= 7'd1;
      ip_q <= 32'd16777216;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        if (cfg_index_i == fse_pkg::CfgHarmonicCount) hc_q <= cfg_data_i[6:0];
        else ip_q <= cfg_data_i;
      end
      if (wr_en) vld_q[AddrW'(in_if.data.index)] <= 1'b1;
      if (st_q == fse_pkg::StFinish && res_free) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      fse_pkg::StIdle: if (in_acc) begin
        it_q <= in_if.data;
        i_q <= 7'd0;
        which_q <= 1'b0;
      end
      fse_pkg::StXmul: if (m_done) begin
        theta_q <= m_p[39:8];
        ph_q <= m_p[39:8];
        i_q <= 7'd1;
        acc_q <= rd_v_q ? (AccW'(rd_c_q) <<< 29) : {AccW{1'b0}};
      end
      fse_pkg::StPrep: begin
        u_q <= sph[30] ? QOne - MW'(ulow) : MW'(ulow);
        neg_q <= sph[31];
        step_q <= fse_pkg::StepZ;
      end
      fse_pkg::StMulWait: if (m_done) begin
        unique case (step_q)
          fse_pkg::StepZ: z_q <= prod_sh;
          fse_pkg::StepR7: r_q <= MW'(fse_pkg::SinC7) - prod_sh;
          fse_pkg::StepR5: r_q <= MW'(fse_pkg::SinC5) - prod_sh;
          fse_pkg::StepR3: r_q <= MW'(fse_pkg::SinC3) - prod_sh;
          fse_pkg::StepR1: r_q <= MW'(fse_pkg::SinC1) - prod_sh;
          fse_pkg::StepSin: r_q <= sclamp;
          fse_pkg::StepMac: acc_q <= acc_q + AccW'(m_p);
          default: ;
        endcase
        if (step_q != fse_pkg::StepMac) step_q <= fse_pkg::step_e'(step_q + 3'd1);
        else if (!which_q) which_q <= 1'b1;
        else begin
          which_q <= 1'b0;
          i_q <= i_q + 7'd1;
          ph_q <= ph_q + theta_q;
        end
      end
      fse_pkg::StFinish: if (res_free) res_q <= res_d;
      default: ;
    endcase
  end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  class fourier_scoreboard;
    longint               cos_tab[fse_pkg::MaxHarmonics];
    longint               sin_tab[fse_pkg::MaxHarmonics];
    logic [6:0]           harm_count;
    logic [31:0]          inv_period;
    fse_pkg::out_item_t   expected_q[$];
    int                   errors;

    function void clear();
      foreach (cos_tab[i]) begin
        cos_tab[i] = 0;
        sin_tab[i] = 0;
      end
      harm_count = 7'd1;
      inv_period = 32'd16777216;
      errors     = 0;
    endfunction

    function void set_cfg(logic idx, logic [31:0] value);
      if (idx == fse_pkg::CfgHarmonicCount) harm_count = value[6:0];
      else inv_period = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int eff_count();
      int n;
      n = harm_count;
      if (n == 0) n = 1;
      if (n > fse_pkg::MaxHarmonics) n = fse_pkg::MaxHarmonics;
      return n;
    endfunction

    function longint quarter_sine(longint u);
      longint z, r;
      z = (u * u) >>> 30;
      r = fse_pkg::SinC9;
      r = longint'(fse_pkg::SinC7) - ((z * r) >>> 30);
      r = longint'(fse_pkg::SinC5) - ((z * r) >>> 30);
      r = longint'(fse_pkg::SinC3) - ((z * r) >>> 30);
      r = longint'(fse_pkg::SinC1) - ((z * r) >>> 30);
      r = (u * r) >>> 30;
      if (r > longint'(fse_pkg::Q30One)) r = fse_pkg::Q30One;
      if (r < 0) r = 0;
      return r;
    endfunction

    function longint turn_sine(logic [31:0] ph);
      longint u, s;
      u = ph[29:0];
      if (ph[30]) u = longint'(fse_pkg::Q30One) - u;
      s = quarter_sine(u);
      return ph[31] ? -s : s;
    endfunction

    function logic signed [31:0] series_at(logic signed [31:0] x);
      longint unsigned xs, prod;
      logic [31:0] theta, ph;
      longint acc, q;
      xs = longint'(x);
      prod = xs * longint'(inv_period);
      theta = prod[39:8];
      acc = cos_tab[0] * (longint'(fse_pkg::Q30One) / 2);
      for (int i = 1; i < eff_count(); i++) begin
        ph = 32'(i) * theta;
        acc += cos_tab[i] * turn_sine(ph + 32'h4000_0000);
        acc += sin_tab[i] * turn_sine(ph);
      end
      q = acc >>> 30;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function void note_input(fse_pkg::in_item_t it);
      fse_pkg::out_item_t r;
      r = '0;
      case (it.operation)
        fse_pkg::OpWrite: begin
          cos_tab[it.index] = longint'(it.cos_coeff_in);
          sin_tab[it.index] = longint'(it.sin_coeff_in);
        end
        fse_pkg::OpRead: begin
          if (it.index >= eff_count()) r.index_error = 1'b1;
          else begin
            r.cos_coeff_out = cos_tab[it.index][23:0];
            r.sin_coeff_out = (it.index == 0) ? 24'd0 : sin_tab[it.index][23:0];
          end
          expected_q.push_back(r);
        end
        fse_pkg::OpEval: begin
          r.series_value = series_at(it.x_value);
          expected_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(fse_pkg::out_item_t got);
      fse_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.series_value !== e.series_value) begin
        $error("series_value expected %0d got %0d", e.series_value, got.series_value);
        errors++;
      end
      if (got.cos_coeff_out !== e.cos_coeff_out) begin
        $error("cos_coeff_out expected %0d got %0d", e.cos_coeff_out, got.cos_coeff_out);
        errors++;
      end
      if (got.sin_coeff_out !== e.sin_coeff_out) begin
        $error("sin_coeff_out expected %0d got %0d", e.sin_coeff_out, got.sin_coeff_out);
        errors++;
      end
      if (got.index_error !== e.index_error) begin
        $error("index_error expected %0d got %0d", e.index_error, got.index_error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  fse_in_if  in_if ();
  fse_out_if out_if ();

  fourier_series_evaluator dut (
    .clk_i,
    .rst_ni,
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  fourier_scoreboard sb = new();
  int tx_pct;
  int rx_pct;
  bit hold_req;

  always #5 clk_i = ~clk_i;

  task automatic write_cfg(logic idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_cfg(idx, value);
  endtask

  task automatic send_item(fse_pkg::in_item_t it);
    while ($urandom_range(99) < tx_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic fse_pkg::in_item_t mk(logic [1:0] op, logic [5:0] idx, logic [23:0] c,
                                           logic [23:0] s, logic [31:0] x);
    fse_pkg::in_item_t it;
    it.operation = op;
    it.index = idx;
    it.cos_coeff_in = c;
    it.sin_coeff_in = s;
    it.x_value = x;
    return it;
  endfunction

  function automatic logic [23:0] rnd_coeff();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic run_random(int n_items, int eval_pct);
    int r;
    logic [1:0] op;
    logic [31:0] x;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2 && n_items > 40) drain();
      r = $urandom_range(99);
      if (r < eval_pct) op = fse_pkg::OpEval;
      else if (r < eval_pct + 5) op = 2'd3;
      else if (r < eval_pct + 50) op = fse_pkg::OpWrite;
      else op = fse_pkg::OpRead;
      x = ($urandom_range(3) == 0) ? 32'($signed(16'($urandom()))) : $urandom();
      send_item(mk(op, 6'($urandom()), rnd_coeff(), rnd_coeff(), x));
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= 1'b0;
    cfg_data_i  <= '0;
    tx_pct = 37;
    rx_pct = 66;
    hold_req = 1'b0;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset config: one harmonic, unit inverse period
    send_item(mk(fse_pkg::OpRead, 6'd0, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpWrite, 6'd0, 24'h7FFFFF, 24'h800000, 32'd0));
    send_item(mk(fse_pkg::OpRead, 6'd0, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpRead, 6'd1, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpEval, 6'd0, 24'd0, 24'd0, 32'h7FFFFFFF));
    send_item(mk(2'd3, 6'd63, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF));
    send_item(mk(fse_pkg::OpWrite, 6'd0, 24'h800000, 24'h7FFFFF, 32'd0));
    send_item(mk(fse_pkg::OpEval, 6'd0, 24'd0, 24'd0, 32'h80000000));
    drain();

    write_cfg(fse_pkg::CfgHarmonicCount, 32'd64);
    write_cfg(fse_pkg::CfgInversePeriod, 32'hFFFFFFFF);
    send_item(mk(fse_pkg::OpWrite, 6'd63, 24'h7FFFFF, 24'h7FFFFF, 32'd0));
    send_item(mk(fse_pkg::OpWrite, 6'd1, 24'h800000, 24'h800000, 32'd0));
    send_item(mk(fse_pkg::OpWrite, 6'd32, 24'h123456, 24'hFEDCBA, 32'd0));
    send_item(mk(fse_pkg::OpRead, 6'd63, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpRead, 6'd1, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpRead, 6'd32, 24'd0, 24'd0, 32'd0));
    send_item(mk(fse_pkg::OpEval, 6'd0, 24'd0, 24'd0, 32'd65536));
    send_item(mk(fse_pkg::OpEval, 6'd0, 24'd0, 24'd0, 32'hFFFFFFFF));
    drain();

    write_cfg(fse_pkg::CfgHarmonicCount, 32'd4);
    write_cfg(fse_pkg::CfgInversePeriod, $urandom());
    run_random(200, 20);
    write_cfg(fse_pkg::CfgHarmonicCount, 32'd0);
    write_cfg(fse_pkg::CfgInversePeriod, 32'd0);
    run_random(100, 20);

    tx_pct = 66;
    rx_pct = 37;
    write_cfg(fse_pkg::CfgHarmonicCount, 32'd2);
    write_cfg(fse_pkg::CfgInversePeriod, 32'hFFFFFFFF);
    run_random(130, 20);
    write_cfg(fse_pkg::CfgHarmonicCount, 32'd127);
    write_cfg(fse_pkg::CfgInversePeriod, $urandom());
    run_random(20, 8);

    tx_pct = 0;
    rx_pct = 0;
    write_cfg(fse_pkg::CfgHarmonicCount, 32'd7);
    write_cfg(fse_pkg::CfgInversePeriod, 32'd16777216);
    hold_req = 1'b1;
    run_random(150, 15);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("** fourier_series_evaluator: PASSED **");
    else $display("** fourier_series_evaluator: FAILED **");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  initial begin : watchdog
    #1_000_000_000;
    $display("** fourier_series_evaluator: FAILED **");
    $finish;
  end
endmodule
